// ===== sv/i2cm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master register access block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_PHASE_TICKS = 1'b0;
	localparam logic REG_ACK_RETRY   = 1'b1;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd15;
	localparam logic [2:0]  ACK_RETRY_RST   = 3'd5;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_byte;
		logic [7:0] byte_count;
		logic       sda_sample;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_pull_low;
		logic [7:0] read_data;
		logic       read_valid;
		logic       last_byte;
		logic       busy_res;
		logic       ack_error;
	} out_item_t;

	// request after classification by the front end
	typedef struct packed {
		logic       tick;
		logic       cmd;
		logic       rd;
		logic [7:0] dev;
		logic [7:0] reg_addr;
		logic [7:0] data;
		logic [7:0] count;
		logic       sda;
	} cls_item_t;

	typedef struct packed {
		logic      valid;
		cls_item_t item;
	} q_head_t;

endpackage

`default_nettype wire

// ===== sv/i2cm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests, decodes the opcode and queues them for the sequencer.
// ----------------------------------------------------------------------------
module i2cm_front
	import i2cm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output q_head_t        head,
	input  wire logic      pop
);

	cls_item_t  mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cls_item_t  cls;
	logic       push;

	always_comb begin
		cls.tick     = (in_data.opcode == OP_TICK);
		cls.cmd      = (in_data.opcode == OP_WRITE) || (in_data.opcode == OP_READ);
		cls.rd       = (in_data.opcode == OP_READ);
		cls.dev      = in_data.device_address;
		cls.reg_addr = in_data.register_address;
		cls.data     = in_data.write_byte;
		// zero count reads one byte
		cls.count    = (in_data.byte_count == 8'd0) ? 8'd1 : in_data.byte_count;
		cls.sda      = in_data.sda_sample;
	end

	assign in_stall   = (count_q == 2'(QDEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/i2cm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: one queued request per cycle unless the output stalls, result into output reg.
// ----------------------------------------------------------------------------
module i2cm_seq
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire q_head_t     head,
	output logic             pop,
	input  wire logic [15:0] phase_ticks,
	input  wire logic [2:0]  ack_retry_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_S1, ST_S2, ST_S3, ST_RS0, ST_TXL, ST_TXH, ST_ACKS, ST_ACKW,
		ST_RXH, ST_RXL, ST_KS, ST_KH, ST_KL, ST_P1, ST_P2, ST_E1, ST_E2
	} step_t;

	step_t      step_q, step_d;
	logic [1:0] ctx_q, ctx_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] left_q, left_d;
	logic [2:0] retry_q, retry_d;
	logic [7:0] dev_q, dev_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;
	logic       rd_q, rd_d;
	logic       out_valid_q;
	out_item_t  out_q, out_d;
	logic [15:0] limit;
	logic [3:0]  bit_inc;
	logic        rx_done;
	cls_item_t   it;

	assign it        = head.item;
	assign pop       = head.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
	assign bit_inc   = bit_q + 4'd1;

	always_comb begin
		step_d  = step_q;
		ctx_d   = ctx_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		left_d  = left_q;
		retry_d = retry_q;
		dev_d   = dev_q;
		reg_d   = reg_q;
		data_d  = data_q;
		rd_d    = rd_q;
		rx_done = 1'b0;
		out_d   = '0;

		if (step_q == ST_IDLE) begin
			if (it.cmd) begin
				dev_d   = it.dev;
				reg_d   = it.reg_addr;
				data_d  = it.data;
				left_d  = it.count;
				rd_d    = it.rd;
				tick_d  = '0;
				bit_d   = '0;
				shift_d = '0;
				retry_d = '0;
				step_d  = ST_S1;
			end
		end else if (it.tick) begin
			if ({1'b0, tick_q} + 17'd1 >= {1'b0, limit}) begin
				tick_d = '0;
				unique case (step_q)
					ST_S1: step_d = ST_S2;
					ST_S2: step_d = ST_S3;
					ST_S3: begin
						bit_d  = '0;
						step_d = ST_TXL;
						if (bit_q == 4'd1) begin
							shift_d = dev_q + 8'd1;
							ctx_d   = 2'd3;
						end else begin
							shift_d = dev_q;
							ctx_d   = 2'd0;
						end
					end
					ST_RS0: step_d = ST_S1;
					ST_TXL: step_d = ST_TXH;
					ST_TXH: begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_inc;
						if (bit_inc >= 4'd8) begin
							retry_d = '0;
							step_d  = ST_ACKS;
						end else begin
							step_d = ST_TXL;
						end
					end
					ST_ACKS: begin
						if (!it.sda) begin
							step_d = ST_ACKW;
						end else if (retry_q >= ack_retry_limit) begin
							step_d = ST_E1;
						end else begin
							retry_d = retry_q + 3'd1;
						end
					end
					ST_ACKW: begin
						unique case (ctx_q)
							2'd0: begin
								shift_d = reg_q;
								bit_d   = '0;
								ctx_d   = 2'd1;
								step_d  = ST_TXL;
							end
							2'd1: begin
								if (rd_q) begin
									bit_d  = 4'd1;
									step_d = ST_RS0;
								end else begin
									shift_d = data_q;
									bit_d   = '0;
									ctx_d   = 2'd2;
									step_d  = ST_TXL;
								end
							end
							2'd2: step_d = ST_P1;
							default: begin
								bit_d   = '0;
								shift_d = '0;
								step_d  = ST_RXH;
							end
						endcase
					end
					ST_RXH: begin
						shift_d = {shift_q[6:0], it.sda};
						bit_d   = bit_inc;
						rx_done = (bit_inc >= 4'd8);
						step_d  = ST_RXL;
					end
					ST_RXL: step_d = (bit_q >= 4'd8) ? ST_KS : ST_RXH;
					ST_KS:  step_d = ST_KH;
					ST_KH:  step_d = ST_KL;
					ST_KL: begin
						if (left_q > 8'd1) begin
							left_d  = left_q - 8'd1;
							bit_d   = '0;
							shift_d = '0;
							step_d  = ST_RXH;
						end else begin
							left_d = '0;
							step_d = ST_P1;
						end
					end
					ST_P1: step_d = ST_P2;
					ST_E1: step_d = ST_E2;
					ST_E2: begin
						out_d.ack_error = 1'b1;
						step_d          = ST_IDLE;
					end
					default: step_d = ST_IDLE;
				endcase
			end else begin
				tick_d = tick_q + 16'd1;
			end
		end

		// pin levels follow the new phase
		unique case (step_d)
			ST_S2, ST_P2, ST_E2: begin
				out_d.scl_level    = 1'b1;
				out_d.sda_pull_low = 1'b1;
			end
			ST_S3, ST_P1, ST_E1: begin
				out_d.scl_level    = 1'b0;
				out_d.sda_pull_low = 1'b1;
			end
			ST_RS0, ST_RXL, ST_ACKW: begin
				out_d.scl_level    = 1'b0;
				out_d.sda_pull_low = 1'b0;
			end
			ST_TXL, ST_TXH: begin
				out_d.scl_level    = (step_d == ST_TXH);
				out_d.sda_pull_low = !shift_d[7];
			end
			ST_KS, ST_KH, ST_KL: begin
				out_d.scl_level    = (step_d == ST_KH);
				out_d.sda_pull_low = (left_d > 8'd1);
			end
			default: begin
				out_d.scl_level    = 1'b1;
				out_d.sda_pull_low = 1'b0;
			end
		endcase

		out_d.read_valid = rx_done;
		out_d.read_data  = rx_done ? shift_d : 8'd0;
		out_d.last_byte  = rx_done && (left_d <= 8'd1);
		out_d.busy_res   = (step_d != ST_IDLE);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			ctx_q       <= '0;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			left_q      <= '0;
			retry_q     <= '0;
			dev_q       <= '0;
			reg_q       <= '0;
			data_q      <= '0;
			rd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q  <= step_d;
				ctx_q   <= ctx_d;
				tick_q  <= tick_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				left_q  <= left_d;
				retry_q <= retry_d;
				dev_q   <= dev_d;
				reg_q   <= reg_d;
				data_q  <= data_d;
				rd_q    <= rd_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/i2c_master_register_access.sv =====
`default_nettype none
// Data path: a request is written into a queue entry on acceptance, and the
// sequencer loads the result of that request into its output register when it
// pops the entry.
// Throughput: one request per cycle unless stalled; the sequencer updates the
// bus state once per queued request; the two-entry queue absorbs output stalls.
// Reset: arst_n clears the queue, the sequencer (idle) and the output valid;
// phase_ticks resets to 15 and ack_retry_limit to 5.
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master register write/read sequencer with an APB configuration port.
// ----------------------------------------------------------------------------
module i2c_master_register_access
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0] phase_ticks_q;
	logic [2:0]  ack_retry_q;
	logic        wr_en;
	q_head_t     head;
	logic        pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_PHASE_TICKS: prdata = {16'd0, phase_ticks_q};
			REG_ACK_RETRY:   prdata = {29'd0, ack_retry_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_retry_q   <= ACK_RETRY_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_PHASE_TICKS) begin
				phase_ticks_q <= pwdata[15:0];
			end else begin
				ack_retry_q <= pwdata[2:0];
			end
		end
	end

	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	i2cm_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.phase_ticks     (phase_ticks_q),
		.ack_retry_limit (ack_retry_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data)
	);

endmodule

`default_nettype wire

// ===== bench/tb_i2c_master_register_access.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access
// Self-checking bench for the I2C master register sequencer. A clocked driver
// feeds requests from a queue; a predictor of the bus sequence computes the
// pin levels, read bytes and status of every request when it is accepted, and
// a clocked monitor checks each result field by field. The configuration is
// rewritten over APB between phases, with read-back.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access;
	import i2cm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	// bus sequence steps; a byte occupies two steps per slot
	// (slot 0 device, 1 register, 2 data, 3 device for read)
	localparam logic [4:0] SQ_IDLE      = 5'd0;
	localparam logic [4:0] SQ_START_A   = 5'd1;
	localparam logic [4:0] SQ_START_B   = 5'd2;
	localparam logic [4:0] SQ_START_C   = 5'd3;
	localparam logic [4:0] SQ_RESTART   = 5'd4;
	localparam logic [4:0] SQ_TX_BASE   = 5'd5;
	localparam logic [4:0] SQ_ACK_BASE  = 5'd13;
	localparam logic [4:0] SQ_RX_HIGH   = 5'd21;
	localparam logic [4:0] SQ_RX_LOW    = 5'd22;
	localparam logic [4:0] SQ_MACK_SET  = 5'd23;
	localparam logic [4:0] SQ_MACK_HIGH = 5'd24;
	localparam logic [4:0] SQ_MACK_LOW  = 5'd25;
	localparam logic [4:0] SQ_STOP_A    = 5'd26;
	localparam logic [4:0] SQ_STOP_B    = 5'd27;
	localparam logic [4:0] SQ_ABORT_A   = 5'd28;
	localparam logic [4:0] SQ_ABORT_B   = 5'd29;

	typedef struct packed {
		logic [4:0]  step;
		logic [15:0] ticks;
		logic [3:0]  bits;
		logic [7:0]  shreg;
		logic [7:0]  remaining;
		logic [2:0]  retries;
		logic [7:0]  dev;
		logic [7:0]  regad;
		logic [7:0]  wdata;
		logic        rd;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	in_item_t   pending_items[$];
	out_item_t  expected_results[$];
	seq_state_t model_seq = '0;
	seq_state_t gen_seq = '0;
	logic [15:0] cfg_phase_ticks = PHASE_TICKS_RST;
	logic [2:0]  cfg_ack_limit = ACK_RETRY_RST;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int n_results = 0;
	int n_bytes = 0;
	int n_aborts = 0;
	int n_transfers = 0;
	out_item_t want_drv;
	out_item_t want_mon;

	i2c_master_register_access u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one request through the bus sequencer: updates st, returns the result
	task automatic bus_step(inout seq_state_t st, input in_item_t it,
			input logic [15:0] pt, input logic [2:0] lim, output out_item_t res);
		logic [4:0]  s;
		logic [4:0]  off;
		logic [1:0]  slot;
		logic [16:0] phase_len;
		logic        got_byte;
		logic        aborted;
		begin
			got_byte = 1'b0;
			aborted = 1'b0;
			if (st.step == SQ_IDLE) begin
				if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
					st.dev = it.device_address;
					st.regad = it.register_address;
					st.wdata = it.write_byte;
					st.remaining = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
					st.rd = (it.opcode == OP_READ);
					st.ticks = '0;
					st.bits = '0;
					st.shreg = '0;
					st.retries = '0;
					st.step = SQ_START_A;
				end
			end else if (it.opcode == OP_TICK) begin
				phase_len = (pt == 16'd0) ? 17'd1 : {1'b0, pt};
				if ({1'b0, st.ticks} + 17'd1 >= phase_len) begin
					st.ticks = '0;
					s = st.step;
					if (s == SQ_START_A) begin
						st.step = SQ_START_B;
					end else if (s == SQ_START_B) begin
						st.step = SQ_START_C;
					end else if (s == SQ_START_C) begin
						// bits marks a repeated start: send the read address
						if (st.bits == 4'd1) begin
							st.shreg = st.dev + 8'd1;
							st.step = SQ_TX_BASE + 5'd6;
						end else begin
							st.shreg = st.dev;
							st.step = SQ_TX_BASE;
						end
						st.bits = '0;
					end else if (s == SQ_RESTART) begin
						st.step = SQ_START_A;
					end else if (s >= SQ_TX_BASE && s < SQ_ACK_BASE) begin
						off = s - SQ_TX_BASE;
						slot = off[2:1];
						if (!off[0]) begin
							st.step = s + 5'd1;
						end else begin
							st.shreg = {st.shreg[6:0], 1'b0};
							st.bits = st.bits + 4'd1;
							if (st.bits >= 4'd8) begin
								st.retries = '0;
								st.step = SQ_ACK_BASE + {2'b00, slot, 1'b0};
							end else begin
								st.step = s - 5'd1;
							end
						end
					end else if (s >= SQ_ACK_BASE && s < SQ_RX_HIGH) begin
						off = s - SQ_ACK_BASE;
						slot = off[2:1];
						if (!off[0]) begin
							if (!it.sda_sample)
								st.step = s + 5'd1;
							else if (st.retries >= lim)
								st.step = SQ_ABORT_A;
							else
								st.retries = st.retries + 3'd1;
						end else if (slot == 2'd0) begin
							st.shreg = st.regad;
							st.bits = '0;
							st.step = SQ_TX_BASE + 5'd2;
						end else if (slot == 2'd1) begin
							if (st.rd) begin
								st.bits = 4'd1;
								st.step = SQ_RESTART;
							end else begin
								st.shreg = st.wdata;
								st.bits = '0;
								st.step = SQ_TX_BASE + 5'd4;
							end
						end else if (slot == 2'd2) begin
							st.step = SQ_STOP_A;
						end else begin
							st.bits = '0;
							st.shreg = '0;
							st.step = SQ_RX_HIGH;
						end
					end else if (s == SQ_RX_HIGH) begin
						st.shreg = {st.shreg[6:0], it.sda_sample};
						st.bits = st.bits + 4'd1;
						if (st.bits >= 4'd8)
							got_byte = 1'b1;
						st.step = SQ_RX_LOW;
					end else if (s == SQ_RX_LOW) begin
						st.step = (st.bits >= 4'd8) ? SQ_MACK_SET : SQ_RX_HIGH;
					end else if (s == SQ_MACK_SET) begin
						st.step = SQ_MACK_HIGH;
					end else if (s == SQ_MACK_HIGH) begin
						st.step = SQ_MACK_LOW;
					end else if (s == SQ_MACK_LOW) begin
						if (st.remaining > 8'd1) begin
							st.remaining = st.remaining - 8'd1;
							st.bits = '0;
							st.shreg = '0;
							st.step = SQ_RX_HIGH;
						end else begin
							st.remaining = '0;
							st.step = SQ_STOP_A;
						end
					end else if (s == SQ_STOP_A) begin
						st.step = SQ_STOP_B;
					end else if (s == SQ_ABORT_A) begin
						st.step = SQ_ABORT_B;
					end else if (s == SQ_ABORT_B) begin
						aborted = 1'b1;
						st.step = SQ_IDLE;
					end else begin
						st.step = SQ_IDLE;
					end
				end else begin
					st.ticks = st.ticks + 16'd1;
				end
			end

			s = st.step;
			res = '0;
			res.scl_level = 1'b1;
			if (s == SQ_START_B || s == SQ_STOP_B || s == SQ_ABORT_B) begin
				res.sda_pull_low = 1'b1;
			end else if (s == SQ_START_C || s == SQ_STOP_A || s == SQ_ABORT_A) begin
				res.scl_level = 1'b0;
				res.sda_pull_low = 1'b1;
			end else if (s == SQ_RESTART || s == SQ_RX_LOW) begin
				res.scl_level = 1'b0;
			end else if (s >= SQ_TX_BASE && s < SQ_ACK_BASE) begin
				off = s - SQ_TX_BASE;
				res.scl_level = off[0];
				res.sda_pull_low = !st.shreg[7];
			end else if (s >= SQ_ACK_BASE && s < SQ_RX_HIGH) begin
				off = s - SQ_ACK_BASE;
				res.scl_level = !off[0];
			end else if (s == SQ_MACK_SET || s == SQ_MACK_HIGH || s == SQ_MACK_LOW) begin
				res.scl_level = (s == SQ_MACK_HIGH);
				res.sda_pull_low = (st.remaining > 8'd1);
			end
			res.read_data = got_byte ? st.shreg : 8'd0;
			res.read_valid = got_byte;
			res.last_byte = got_byte && (st.remaining <= 8'd1);
			res.busy_res = (st.step != SQ_IDLE);
			res.ack_error = aborted;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		begin
			if (want !== got) begin
				errors = errors + 1;
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			end
		end
	endtask

	// queue a request, tracking where the sequence will be once it is taken
	task automatic push_item(input logic [1:0] op, input logic [7:0] dev,
			input logic [7:0] regad, input logic [7:0] wdata, input logic [7:0] cnt,
			input logic sda);
		in_item_t  it;
		out_item_t unused;
		begin
			it.opcode = op;
			it.device_address = dev;
			it.register_address = regad;
			it.write_byte = wdata;
			it.byte_count = cnt;
			it.sda_sample = sda;
			bus_step(gen_seq, it, cfg_phase_ticks, cfg_ack_limit, unused);
			pending_items.push_back(it);
		end
	endtask

	// mostly well-formed transfers; nack_pct sets how often an ack goes missing
	task automatic make_items(input int n, input int nack_pct);
		logic [1:0] op;
		logic [7:0] cnt;
		logic [4:0] off;
		logic       sda;
		int         pick;
		begin
			repeat (n) begin
				pick = int'($urandom_range(99, 0));
				if (gen_seq.step == SQ_IDLE)
					op = (pick < 85) ? logic'($urandom_range(1, 0)) + OP_WRITE :
						(pick < 95) ? OP_TICK : OP_UNUSED;
				else
					op = (pick < 94) ? OP_TICK :
						(pick < 98) ? logic'($urandom_range(1, 0)) + OP_WRITE : OP_UNUSED;
				cnt = 8'($urandom_range(255, 0));
				if (op == OP_READ) begin
					case ($urandom_range(9, 0))
						0: begin
							cnt = 8'd0;
						end
						9: begin
							cnt = 8'($urandom_range(12, 4));
						end
						default: begin
							cnt = 8'($urandom_range(3, 1));
						end
					endcase
				end
				off = gen_seq.step - SQ_ACK_BASE;
				if (gen_seq.step >= SQ_ACK_BASE && gen_seq.step < SQ_RX_HIGH && !off[0])
					sda = ($urandom_range(99, 0) < nack_pct);
				else
					sda = 1'($urandom_range(1, 0));
				push_item(op, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
					8'($urandom_range(255, 0)), cnt, sda);
			end
		end
	endtask

	task automatic wait_idle;
		begin
			while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
				@(posedge clk);
		end
	endtask

	// APB write followed by a read-back of the same register
	task automatic reg_write(input logic idx, input logic [31:0] value);
		logic [31:0] mask;
		begin
			mask = (idx == REG_PHASE_TICKS) ? 32'h0000_FFFF : 32'h0000_0007;
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= value;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (idx == REG_PHASE_TICKS)
				cfg_phase_ticks = value[15:0];
			else
				cfg_ack_limit = value[2:0];
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(negedge clk);
			if ((prdata & mask) !== (value & mask)) begin
				errors = errors + 1;
				$display("%0t: read-back of register %0d: expected %h, got %h",
					$time, idx, value & mask, prdata & mask);
			end
			do @(posedge clk); while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic run_phase(input logic [15:0] pt, input logic [2:0] lim, input int n,
			input int gap, input int stall, input int nack_pct);
		begin
			reg_write(REG_PHASE_TICKS, {16'd0, pt});
			reg_write(REG_ACK_RETRY, {29'd0, lim});
			send_gap_pct = gap;
			recv_stall_pct = stall;
			make_items(n, nack_pct);
			wait_idle();
		end
	endtask

	// driver: predicts on acceptance, then offers the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				if (model_seq.step == SQ_IDLE &&
						(in_data.opcode == OP_WRITE || in_data.opcode == OP_READ))
					n_transfers = n_transfers + 1;
				bus_step(model_seq, in_data, cfg_phase_ticks, cfg_ack_limit, want_drv);
				n_bytes = n_bytes + int'(want_drv.read_valid);
				n_aborts = n_aborts + int'(want_drv.ack_error);
				expected_results.push_back(want_drv);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors = errors + 1;
					$display("%0t: unexpected result: expected none, got %h", $time, out_data);
				end else begin
					want_mon = expected_results.pop_front();
					n_results = n_results + 1;
					check_field("scl_level", 8'(want_mon.scl_level),
						8'(out_data.scl_level));
					check_field("sda_pull_low", 8'(want_mon.sda_pull_low),
						8'(out_data.sda_pull_low));
					check_field("read_data", want_mon.read_data, out_data.read_data);
					check_field("read_valid", 8'(want_mon.read_valid),
						8'(out_data.read_valid));
					check_field("last_byte", 8'(want_mon.last_byte),
						8'(out_data.last_byte));
					check_field("busy_res", 8'(want_mon.busy_res),
						8'(out_data.busy_res));
					check_field("ack_error", 8'(want_mon.ack_error),
						8'(out_data.ack_error));
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: ignored requests while idle and busy
		push_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		push_item(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
		push_item(OP_READ, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
		push_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		repeat (17) push_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		wait_idle();

		// zero phase length, then limit changes while a transfer may be running
		run_phase(16'd0, 3'd7, 100, 0, 0, 10);
		run_phase(16'd1, 3'd0, 200, 56, 0, 10);
		run_phase(16'd2, 3'd3, 200, 0, 56, 20);
		run_phase(16'hFFFF, 3'd5, 40, 30, 30, 10);

		// sender holds off until everything is back, batch by batch
		reg_write(REG_PHASE_TICKS, 32'd1);
		reg_write(REG_ACK_RETRY, 32'd2);
		repeat (12) begin
			make_items(25, 15);
			wait_idle();
		end

		// one longer read, with the read address wrapping round
		reg_write(REG_ACK_RETRY, 32'd7);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		while (gen_seq.step != SQ_IDLE)
			make_items(1, 0);
		push_item(OP_READ, 8'hFF, 8'h5A, 8'hA5, 8'd20, 1'b0);
		while (gen_seq.step != SQ_IDLE)
			make_items(1, 0);
		wait_idle();

		run_phase(16'd3, 3'd1, 200, 30, 30, 35);
		run_phase(16'd1, 3'd6, 150, 56, 0, 10);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Checked %0d results: %0d transfers started, %0d bytes read, %0d aborted",
			n_results, n_transfers, n_bytes, n_aborts);
		$display("Phase lengths 0 to 65535, retry limits 0 to 7, with random idling and stalls");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding", expected_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
